// ----- hdl/swhsr_pkg.sv -----
// Package for the single-wire humidity sensor reader.
// Holds payload structs, phase enum, status and register index codes.
// No dependencies.
`timescale 1ns / 1ps

package swhsr_pkg;

  // Data frame: 40 bits, five bytes, MSB first
  localparam int DATA_BIT_COUNT = 40;
  localparam int BIT_IDX_W      = 6;
  localparam int TIMEOUT_W      = 6;
  localparam int START_W        = 14;
  localparam int RESULT_W       = 12;

  // Configuration port
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LOW_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_PHASE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH_TIMEOUT  = 3'd4;

  // Register reset values
  localparam logic [START_W-1:0]   START_LOW_RESET   = 14'd10000;
  localparam logic [TIMEOUT_W-1:0] ACK_LOW_RESET     = 6'd20;
  localparam logic [TIMEOUT_W-1:0] ACK_PHASE_RESET   = 6'd44;
  localparam logic [TIMEOUT_W-1:0] BIT_LOW_RESET     = 6'd33;
  localparam logic [TIMEOUT_W-1:0] BIT_HIGH_RESET    = 6'd38;

  // Reading status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_ACK_LOW  = 3'd2,
    PH_ACK_HIGH = 3'd3,
    PH_ACK_END  = 3'd4,
    PH_BIT_LOW  = 3'd5,
    PH_BIT_HIGH = 3'd6
  } phase_t;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic [1:0]          status;
    logic [RESULT_W-1:0] humidity;
    logic [RESULT_W-1:0] temperature;
  } out_item_t;

endpackage

// ----- hdl/single_wire_humidity_sensor_reader_top.sv -----
// Single-wire humidity/temperature sensor reader, top level.
// Depends on swhsr_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one transfer per 2 us sampling
//   tick, carrying the sampled data line level and a start request. A start
//   request is honored only while no reading is in progress.
//   Output channel (out_valid/out_stall/out_data): exactly one result per
//   input tick: the open-drain drive, busy, a one-tick done flag with status
//   (ok, timeout, checksum mismatch) and the last good humidity/temperature
//   as integer*10+decimal.
//   Results are registered in the result register, or in the skid register
//   on a stall. Throughput is one tick per cycle while in_stall is low: the
//   sequencer update is a single pass of logic from state to result register.
//   When the receiver stalls, the result register holds and one more result
//   goes into a skid register; in_stall rises only while the skid is full.
//   Configuration writes (cfg_wr_en/cfg_index/cfg_data) take effect at once
//   and are expected only while idle.
//   Synchronous reset returns the sequencer to idle, clears the stored
//   readings, loads register defaults and empties both output registers.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_top
  import swhsr_pkg::*;
#(
  parameter int COUNT_WIDTH = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Compare width covering both the tick counter and the start register
  localparam int CMP_W = (COUNT_WIDTH > START_W) ? COUNT_WIDTH : START_W;

  // Configuration registers
  logic [START_W-1:0]   start_low_ticks;
  logic [TIMEOUT_W-1:0] ack_low_timeout;
  logic [TIMEOUT_W-1:0] ack_phase_timeout;
  logic [TIMEOUT_W-1:0] bit_low_timeout;
  logic [TIMEOUT_W-1:0] bit_high_timeout;

  // Sequencer state
  phase_t                   phase, phase_next;
  logic [COUNT_WIDTH-1:0]   tick_count, tick_count_next;
  logic [BIT_IDX_W-1:0]     bit_index, bit_index_next;
  logic [TIMEOUT_W-1:0]     low_ticks, low_ticks_next;
  logic [DATA_BIT_COUNT-1:0] received_bits, received_bits_next;
  logic [RESULT_W-1:0]      last_humidity, last_humidity_next;
  logic [RESULT_W-1:0]      last_temperature, last_temperature_next;

  // Output side
  out_item_t result;
  out_item_t skid_data;
  logic      skid_valid;
  logic      in_fire;
  logic      out_fire;

  // Wait-phase helpers
  logic                   want_level;
  logic [TIMEOUT_W-1:0]   wait_limit;
  logic [TIMEOUT_W-1:0]   limit_eff;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   level_match;
  logic                   wait_timeout;

  // Frame decode helpers
  logic                      new_bit;
  logic [DATA_BIT_COUNT-1:0] bits_shift;
  logic [BIT_IDX_W-1:0]      index_inc;
  logic [7:0]                byte0, byte1, byte2, byte3, byte4;
  logic [7:0]                byte_sum;

  // byte_hi * 10 + byte_lo, as shifts and adds
  function automatic logic [RESULT_W-1:0] tens_plus(input logic [7:0] hi,
                                                    input logic [7:0] lo);
    logic [RESULT_W-1:0] h;
    h = RESULT_W'(hi);
    return (h << 3) + (h << 1) + RESULT_W'(lo);
  endfunction

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks   <= START_LOW_RESET;
      ack_low_timeout   <= ACK_LOW_RESET;
      ack_phase_timeout <= ACK_PHASE_RESET;
      bit_low_timeout   <= BIT_LOW_RESET;
      bit_high_timeout  <= BIT_HIGH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_START_LOW_TICKS:   start_low_ticks   <= cfg_data;
        CFG_ACK_LOW_TIMEOUT:   ack_low_timeout   <= cfg_data[TIMEOUT_W-1:0];
        CFG_ACK_PHASE_TIMEOUT: ack_phase_timeout <= cfg_data[TIMEOUT_W-1:0];
        CFG_BIT_LOW_TIMEOUT:   bit_low_timeout   <= cfg_data[TIMEOUT_W-1:0];
        CFG_BIT_HIGH_TIMEOUT:  bit_high_timeout  <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared wait logic: expected level and timeout of the current phase
  always_comb begin
    case (phase)
      PH_ACK_LOW:  begin want_level = 1'b0; wait_limit = ack_low_timeout;   end
      PH_ACK_HIGH: begin want_level = 1'b1; wait_limit = ack_phase_timeout; end
      PH_ACK_END:  begin want_level = 1'b0; wait_limit = ack_phase_timeout; end
      PH_BIT_LOW:  begin want_level = 1'b1; wait_limit = bit_low_timeout;   end
      PH_BIT_HIGH: begin want_level = 1'b0; wait_limit = bit_high_timeout;  end
      default:     begin want_level = 1'b0; wait_limit = bit_high_timeout;  end
    endcase
  end

  assign limit_eff    = (wait_limit == '0) ? TIMEOUT_W'(1) : wait_limit;
  assign tick_inc     = tick_count + COUNT_WIDTH'(1);
  assign level_match  = (in_data.line_level == want_level);
  assign wait_timeout = CMP_W'(tick_inc) >= CMP_W'(limit_eff);

  // Bit decision and frame fields once the last bit lands
  assign new_bit    = CMP_W'(tick_count) > CMP_W'(low_ticks);
  assign bits_shift = {received_bits[DATA_BIT_COUNT-2:0], new_bit};
  assign index_inc  = bit_index + BIT_IDX_W'(1);
  assign byte0      = bits_shift[39:32];
  assign byte1      = bits_shift[31:24];
  assign byte2      = bits_shift[23:16];
  assign byte3      = bits_shift[15:8];
  assign byte4      = bits_shift[7:0];
  assign byte_sum   = byte0 + byte1 + byte2 + byte3;

  // Sequencer next state and result for one tick
  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    low_ticks_next        = low_ticks;
    received_bits_next    = received_bits;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    result                = '0;

    case (phase)
      PH_IDLE: begin
        if (in_data.start_request) begin
          phase_next         = PH_START;
          tick_count_next    = COUNT_WIDTH'(1);
          bit_index_next     = '0;
          received_bits_next = '0;
          result.drive_low   = 1'b1;
        end
      end
      PH_START: begin
        if (CMP_W'(tick_count) >= CMP_W'(start_low_ticks) || tick_count == '1) begin
          phase_next      = PH_ACK_LOW;
          tick_count_next = '0;
        end else begin
          tick_count_next  = tick_inc;
          result.drive_low = 1'b1;
        end
      end
      PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_END, PH_BIT_LOW: begin
        if (level_match) begin
          tick_count_next = '0;
          case (phase)
            PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
            PH_ACK_HIGH: phase_next = PH_ACK_END;
            PH_ACK_END:  phase_next = PH_BIT_LOW;
            default: begin
              phase_next     = PH_BIT_HIGH;
              low_ticks_next = tick_count[TIMEOUT_W-1:0];
            end
          endcase
        end else begin
          tick_count_next = tick_inc;
          if (wait_timeout) begin
            result.done_res = 1'b1;
            result.status   = ST_TIMEOUT;
          end
        end
      end
      PH_BIT_HIGH: begin
        if (level_match) begin
          tick_count_next    = '0;
          received_bits_next = bits_shift;
          bit_index_next     = index_inc;
          if (index_inc >= BIT_IDX_W'(DATA_BIT_COUNT)) begin
            result.done_res = 1'b1;
            if (byte_sum == byte4) begin
              last_humidity_next    = tens_plus(byte0, byte1);
              last_temperature_next = tens_plus(byte2, byte3);
            end else begin
              result.status = ST_CHECKSUM;
            end
          end else begin
            phase_next = PH_BIT_LOW;
          end
        end else begin
          tick_count_next = tick_inc;
          if (wait_timeout) begin
            result.done_res = 1'b1;
            result.status   = ST_TIMEOUT;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    // A finished reading, good or not, returns to idle
    if (result.done_res) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end

    result.busy_res    = (phase_next != PH_IDLE);
    result.humidity    = last_humidity_next;
    result.temperature = last_temperature_next;
  end

  // State registers advance on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      low_ticks        <= '0;
      received_bits    <= '0;
      last_humidity    <= '0;
      last_temperature <= '0;
    end else if (in_fire) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      low_ticks        <= low_ticks_next;
      received_bits    <= received_bits_next;
      last_humidity    <= last_humidity_next;
      last_temperature <= last_temperature_next;
    end
  end

  // Result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= result;
      end
    end else if (in_fire) begin
      skid_data <= result;
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while result register empty");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("reading reported done but still busy");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.done_res) |-> (out_data.status == ST_OK))
    else $error("nonzero status without done");

  a_drive_when_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.drive_low) |-> out_data.busy_res)
    else $error("line driven low outside a reading");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_IDX_W'(DATA_BIT_COUNT))
    else $error("bit index past end of frame");

endmodule
